FILE: rtl/core/mic_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mic_pkg: shared types and constants for the iron calibration core
// Field widths, fixed-point formats, operand widths of the shared multiplier
// and divider, opcodes, register indexes and payload structs.
// ----------------------------------------------------------------------------
package mic_pkg;

	// soft-iron scale format
	localparam int SCALE_FRAC_BITS = 14;
	localparam int SCALE_W         = SCALE_FRAC_BITS + 2;
	localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(1) << SCALE_FRAC_BITS;
	localparam logic [SCALE_W-1:0] SCALE_SAT = '1;

	// sensitivity in 1/16 mG per lsb, times 819
	localparam int GAIN_W = 17;
	localparam logic [GAIN_W-1:0] GAIN_14 = 17'd78592;
	localparam logic [GAIN_W-1:0] GAIN_16 = 17'd19648;

	// shared multiplier
	localparam int MUL_AW = 25;
	localparam int MUL_BW = (SCALE_W > 18) ? SCALE_W : 18;
	localparam int MUL_PW = MUL_AW + MUL_BW;

	// finish arithmetic
	localparam int W_W   = 25;
	localparam int SUM_W = 27;
	localparam int DEN_W = 27;

	// shared divider
	localparam int DIV_NW = (SUM_W + 1 + SCALE_FRAC_BITS > 42) ?
		(SUM_W + 1 + SCALE_FRAC_BITS) : 42;
	localparam int DIV_DW = DEN_W;
	localparam int DIV_CW = $clog2(DIV_NW);

	// correction arithmetic: divide by 1638 as halving then radix-256 digits
	// of a divide by 819, each digit from a reciprocal multiply
	localparam logic [MUL_PW-1:0] CORR_HALF = MUL_PW'(819);
	localparam int DIG_W  = 8;
	localparam int DIG_N  = 6;
	localparam int DIG_NW = DIG_W * DIG_N;
	localparam int DIG_CW = $clog2(DIG_N);
	localparam int REM_W  = 10;
	localparam int CX_W   = REM_W + DIG_W;
	localparam logic [REM_W-1:0]  CORR_D   = 10'd819;
	localparam logic [MUL_AW-1:0] RECIP_M  = MUL_AW'(327761);
	localparam int                RECIP_SH = 28;
	localparam int MAG_W  = 32;
	localparam int HALF_W = MAG_W / 2;
	localparam int TOT_W  = MAG_W + SCALE_W;
	localparam int SH     = SCALE_FRAC_BITS + 8;
	localparam int FM_W   = TOT_W + 1 - SH;
	localparam int FIELD_W = 24;
	localparam logic [FM_W-1:0] FIELD_POS_LIM = FM_W'(8388607);
	localparam logic [FM_W-1:0] FIELD_NEG_LIM = FM_W'(8388608);
	localparam logic [FIELD_W-1:0] FIELD_MAX = 24'h7FFFFF;
	localparam logic [FIELD_W-1:0] FIELD_MIN = 24'h800000;

	localparam logic signed [15:0] MIN_RESET = 16'sd32767;
	localparam logic signed [15:0] MAX_RESET = -16'sd32767;

	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_START  = 2'd1,
		OP_FINISH = 2'd2,
		OP_NONE   = 2'd3
	} mic_op_t;

	typedef enum logic [1:0] {
		CFG_ASA_X = 2'd0,
		CFG_ASA_Y = 2'd1,
		CFG_ASA_Z = 2'd2,
		CFG_RES   = 2'd3
	} mic_cfg_idx_t;

	typedef struct packed {
		mic_op_t            opcode;
		logic signed [15:0] raw_x;
		logic signed [15:0] raw_y;
		logic signed [15:0] raw_z;
		logic               data_ready;
		logic               overflow;
	} mic_in_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] field_x;
		logic signed [FIELD_W-1:0] field_y;
		logic signed [FIELD_W-1:0] field_z;
		logic                      calibrating;
		logic                      cal_error;
	} mic_out_t;

endpackage

FILE: rtl/core/magnetometer_iron_calibration_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magnetometer_iron_calibration_core: hard/soft iron calibrated magnetometer
// Takes raw 3-axis samples and calibration opcodes, gives corrected fields.
// ----------------------------------------------------------------------------
// Usage:
// - input channel in_valid/in_stall/in_data carries one request: an opcode
//   (sample, start, finish) with raw x/y/z and the ready/overflow flags
// - output channel out_valid/out_stall/out_data gives one result per request:
//   corrected x/y/z field in 1/16 mG, calibrating and cal_error flags
// - cfg_valid/cfg_ready/cfg_index/cfg_data write the asa bytes and the
//   resolution bit; cfg_ready is always high, write only while idle
// - one request at a time: a shared multiplier works through the three axes;
//   per axis the divide by 1638 is done as six radix-256 reciprocal digits
// - after a sample, start or unused request the next request can enter once
//   its result is loaded into the output register
// - a finish that passes its checks first computes the range weights and
//   the three scale divisions in the bit-serial divider
// - reset gives asa 128, 14-bit resolution, zero offsets, unit scales
// - a finished result waits in the output register while out_stall is high;
//   the next request is accepted meanwhile and waits for the register to free
// ----------------------------------------------------------------------------
module magnetometer_iron_calibration_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  mic_pkg::mic_in_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output mic_pkg::mic_out_t out_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [7:0]        cfg_data
);
	import mic_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_FW, S_FWC, S_FDS, S_FDW,
		S_CG, S_CP, S_CN, S_CQ, S_CR, S_CLO, S_CHI, S_CSUM, S_DONE
	} state_t;

	state_t                    state_q;
	logic [1:0]                ax_q;
	logic [7:0]                asa_q [3];
	logic                      res_q;
	logic signed [15:0]        held_q [3];
	logic signed [15:0]        min_q [3];
	logic signed [15:0]        max_q [3];
	logic signed [16:0]        off2_q [3];
	logic [SCALE_W-1:0]        scale_q [3];
	logic                      track_q;
	logic                      err_q;
	logic [W_W-1:0]            w_q [3];
	logic [MAG_W-1:0]          mag_q;
	logic [DIG_NW-1:0]         n_q;
	logic [REM_W-1:0]          r_q;
	logic [DIG_CW-1:0]         dig_q;
	logic [HALF_W+SCALE_W-1:0] lo_q;
	logic                      sign_q;
	logic [FIELD_W-1:0]        fld_q [3];
	logic                      out_valid_q;
	mic_out_t                  out_q;

	logic signed [15:0]        nh [3];
	logic                      bad;
	logic [8:0]                asa9;
	logic signed [16:0]        rng;
	logic signed [18:0]        d;
	logic [17:0]               dmag;
	logic [SUM_W-1:0]          sum;
	logic [DEN_W-1:0]          den3;
	logic [CX_W-1:0]           cx;
	logic [DIG_W-1:0]          qd;
	logic [CX_W-1:0]           cq;
	logic [TOT_W-1:0]          total;
	logic [TOT_W:0]            rnd;
	logic [FM_W-1:0]           fmag;
	logic [FIELD_W-1:0]        fsat;
	logic [SCALE_W-1:0]        snew;

	logic [MUL_AW-1:0]         mul_a;
	logic [MUL_BW-1:0]         mul_b;
	logic [MUL_PW-1:0]         mul_p;
	logic                      div_start;
	logic [DIV_NW-1:0]         div_num;
	logic [DIV_DW-1:0]         div_den;
	logic                      div_busy;
	logic                      div_done;
	logic [DIV_NW-1:0]         div_quo;

	// held values after a sample request
	always_comb begin
		nh[0] = held_q[0];
		nh[1] = held_q[1];
		nh[2] = held_q[2];
		if (in_data.data_ready && !in_data.overflow) begin
			nh[0] = in_data.raw_x;
			nh[1] = in_data.raw_y;
			nh[2] = in_data.raw_z;
		end
		bad = (max_q[0] <= min_q[0]) || (max_q[1] <= min_q[1]) ||
			(max_q[2] <= min_q[2]);
	end

	// per-axis operands
	always_comb begin
		asa9 = {1'b0, asa_q[ax_q]} + 9'd128;
		rng  = {max_q[ax_q][15], max_q[ax_q]} - {min_q[ax_q][15], min_q[ax_q]};
		d    = {{2{held_q[ax_q][15]}}, held_q[ax_q], 1'b0} -
			{{2{off2_q[ax_q][16]}}, off2_q[ax_q]};
		dmag = d[18] ? 18'(-d) : d[17:0];
		sum  = SUM_W'(w_q[0]) + SUM_W'(w_q[1]) + SUM_W'(w_q[2]);
		den3 = DEN_W'(w_q[ax_q]) + (DEN_W'(w_q[ax_q]) << 1);
		snew = (div_quo > DIV_NW'(SCALE_SAT)) ? SCALE_SAT : div_quo[SCALE_W-1:0];
	end

	// quotient digit and remainder of the divide by 819
	always_comb begin
		cx = {r_q, n_q[DIG_NW-1 -: DIG_W]};
		qd = mul_p[RECIP_SH+DIG_W-1:RECIP_SH];
		cq = cx - CX_W'(qd) * CX_W'(CORR_D);
	end

	// field rounding and saturation
	always_comb begin
		total = (TOT_W'(mul_p[HALF_W+SCALE_W-1:0]) << HALF_W) + TOT_W'(lo_q);
		rnd   = (TOT_W+1)'(total) + ((TOT_W+1)'(1) << (SH - 1));
		fmag  = rnd[TOT_W:SH];
		if (sign_q) begin
			fsat = (fmag > FIELD_NEG_LIM) ? FIELD_MIN : FIELD_W'(-fmag);
		end else begin
			fsat = (fmag > FIELD_POS_LIM) ? FIELD_MAX : fmag[FIELD_W-1:0];
		end
	end

	// multiplier operand selection
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_FW: begin
				mul_a = MUL_AW'(rng[15:0]);
				mul_b = MUL_BW'(asa9);
			end
			S_CG: begin
				mul_a = MUL_AW'(res_q ? GAIN_16 : GAIN_14);
				mul_b = MUL_BW'(asa9);
			end
			S_CP: begin
				mul_a = mul_p[MUL_AW-1:0];
				mul_b = MUL_BW'(dmag);
			end
			S_CQ: begin
				mul_a = RECIP_M;
				mul_b = MUL_BW'(cx);
			end
			S_CLO: begin
				mul_a = MUL_AW'(mag_q[HALF_W-1:0]);
				mul_b = MUL_BW'(scale_q[ax_q]);
			end
			S_CHI: begin
				mul_a = MUL_AW'(mag_q[MAG_W-1:HALF_W]);
				mul_b = MUL_BW'(scale_q[ax_q]);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// divider operands for the soft-iron scales
	always_comb begin
		div_start = (state_q == S_FDS);
		div_num   = (DIV_NW'(sum) << SCALE_FRAC_BITS) + DIV_NW'(den3 >> 1);
		div_den   = den3;
	end

	mic_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (mul_p)
	);

	mic_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (div_quo)
	);

	// sequencer, calibration state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ax_q        <= '0;
			res_q       <= 1'b0;
			track_q     <= 1'b0;
			err_q       <= 1'b0;
			mag_q       <= '0;
			n_q         <= '0;
			r_q         <= '0;
			dig_q       <= '0;
			lo_q        <= '0;
			sign_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			for (int i = 0; i < 3; i++) begin
				asa_q[i]   <= 8'd128;
				held_q[i]  <= '0;
				min_q[i]   <= MIN_RESET;
				max_q[i]   <= MAX_RESET;
				off2_q[i]  <= '0;
				scale_q[i] <= SCALE_ONE;
				w_q[i]     <= '0;
				fld_q[i]   <= '0;
			end
		end else begin
			// register writes
			if (cfg_valid) begin
				unique case (mic_cfg_idx_t'(cfg_index))
					CFG_ASA_X: asa_q[0] <= cfg_data;
					CFG_ASA_Y: asa_q[1] <= cfg_data;
					CFG_ASA_Z: asa_q[2] <= cfg_data;
					CFG_RES:   res_q    <= cfg_data[0];
					default:   res_q    <= res_q;
				endcase
			end

			// result taken and no new one loaded this cycle
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						ax_q    <= '0;
						state_q <= S_CG;
						unique case (in_data.opcode)
							OP_SAMPLE: begin
								for (int i = 0; i < 3; i++) begin
									held_q[i] <= nh[i];
									if (track_q) begin
										if (nh[i] < min_q[i]) min_q[i] <= nh[i];
										if (nh[i] > max_q[i]) max_q[i] <= nh[i];
									end
								end
							end
							OP_START: begin
								for (int i = 0; i < 3; i++) begin
									off2_q[i]  <= '0;
									scale_q[i] <= SCALE_ONE;
									min_q[i]   <= MIN_RESET;
									max_q[i]   <= MAX_RESET;
								end
								track_q <= 1'b1;
							end
							OP_FINISH: begin
								if (!track_q) begin
									err_q <= 1'b1;
								end else begin
									track_q <= 1'b0;
									for (int i = 0; i < 3; i++) begin
										off2_q[i] <= {min_q[i][15], min_q[i]} +
											{max_q[i][15], max_q[i]};
									end
									if (bad) begin
										err_q <= 1'b1;
										for (int i = 0; i < 3; i++) begin
											scale_q[i] <= SCALE_ONE;
										end
									end else begin
										state_q <= S_FW;
									end
								end
							end
							default: state_q <= S_CG;
						endcase
					end
				end
				// range weights
				S_FW: state_q <= S_FWC;
				S_FWC: begin
					w_q[ax_q] <= mul_p[W_W-1:0];
					if (ax_q == 2'd2) begin
						ax_q    <= '0;
						state_q <= S_FDS;
					end else begin
						ax_q    <= ax_q + 1'b1;
						state_q <= S_FW;
					end
				end
				// soft-iron scale divisions
				S_FDS: state_q <= S_FDW;
				S_FDW: begin
					if (div_done) begin
						scale_q[ax_q] <= snew;
						if (ax_q == 2'd2) begin
							err_q   <= 1'b0;
							ax_q    <= '0;
							state_q <= S_CG;
						end else begin
							ax_q    <= ax_q + 1'b1;
							state_q <= S_FDS;
						end
					end
				end
				// field correction
				S_CG: state_q <= S_CP;
				S_CP: begin
					sign_q  <= d[18];
					state_q <= S_CN;
				end
				// rounded and halved product, ready for the digit loop
				S_CN: begin
					n_q     <= DIG_NW'((mul_p + CORR_HALF) >> 1);
					r_q     <= '0;
					dig_q   <= '0;
					mag_q   <= '0;
					state_q <= S_CQ;
				end
				S_CQ: state_q <= S_CR;
				S_CR: begin
					r_q   <= cq[REM_W-1:0];
					n_q   <= n_q << DIG_W;
					mag_q <= {mag_q[MAG_W-DIG_W-1:0], qd};
					if (dig_q == DIG_CW'(DIG_N - 1)) begin
						dig_q   <= '0;
						state_q <= S_CLO;
					end else begin
						dig_q   <= dig_q + 1'b1;
						state_q <= S_CQ;
					end
				end
				S_CLO: state_q <= S_CHI;
				S_CHI: begin
					lo_q    <= mul_p[HALF_W+SCALE_W-1:0];
					state_q <= S_CSUM;
				end
				S_CSUM: begin
					fld_q[ax_q] <= fsat;
					if (ax_q == 2'd2) begin
						ax_q    <= '0;
						state_q <= S_DONE;
					end else begin
						ax_q    <= ax_q + 1'b1;
						state_q <= S_CG;
					end
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q       <= 1'b1;
						out_q.field_x     <= fld_q[0];
						out_q.field_y     <= fld_q[1];
						out_q.field_z     <= fld_q[2];
						out_q.calibrating <= track_q;
						out_q.cal_error   <= err_q;
						state_q           <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// divider is never left running while a request can enter
	a_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !div_busy)
		else $error("divider busy while idle");

	// start request opens min/max tracking
	a_start_track: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && in_data.opcode == OP_START) |=> track_q)
		else $error("tracking not set after start");

	// soft-iron scales never collapse to zero
	a_scale_nz: assert property (@(posedge clk) disable iff (!arst_n)
		(scale_q[0] != '0) && (scale_q[1] != '0) && (scale_q[2] != '0))
		else $error("zero soft-iron scale");

endmodule

FILE: rtl/core/mic_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mic_mul: shared unsigned multiplier
// One product per cycle with a registered result, used for gains, products,
// range weights and the scale partial products.
// ----------------------------------------------------------------------------
module mic_mul (
	input  logic                      clk,
	input  logic [mic_pkg::MUL_AW-1:0] a,
	input  logic [mic_pkg::MUL_BW-1:0] b,
	output logic [mic_pkg::MUL_PW-1:0] p_q
);
	import mic_pkg::*;

	// registered product
	always_ff @(posedge clk) begin
		p_q <= MUL_PW'(a) * MUL_PW'(b);
	end

endmodule

FILE: rtl/core/mic_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mic_div: shared restoring divider
// Unsigned long division, one quotient bit per cycle; done pulses once the
// quotient is complete and the quotient then holds until the next start.
// ----------------------------------------------------------------------------
module mic_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [mic_pkg::DIV_NW-1:0] num,
	input  logic [mic_pkg::DIV_DW-1:0] den,
	output logic                       busy,
	output logic                       done,
	output logic [mic_pkg::DIV_NW-1:0] quo
);
	import mic_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [DIV_CW-1:0] cnt_q;
	logic [DIV_NW-1:0] num_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW:0]   rem_sh;
	logic [DIV_DW:0]   diff;

	// trial subtract
	always_comb begin
		rem_sh = {rem_q, num_q[DIV_NW-1]};
		diff   = rem_sh - {1'b0, den_q};
	end

	// iteration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			num_q  <= '0;
			den_q  <= '0;
			rem_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				num_q  <= num;
				den_q  <= den;
				rem_q  <= '0;
			end else if (busy_q) begin
				if (!diff[DIV_DW]) begin
					rem_q <= diff[DIV_DW-1:0];
					num_q <= {num_q[DIV_NW-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh[DIV_DW-1:0];
					num_q <= {num_q[DIV_NW-2:0], 1'b0};
				end
				if (cnt_q == DIV_CW'(DIV_NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = num_q;

endmodule
